/* design/ffsa_pkg.sv */
package ffsa_pkg;

	localparam int MAX_SEGMENTS_DEF = 16;
	localparam int ADDR_BITS_DEF    = 16;

	typedef enum logic [1:0] {
		RQ_ALLOC  = 2'd0,
		RQ_FREE   = 2'd1,
		RQ_RESIZE = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFIT  = 2'd1,
		STAT_NOADDR = 2'd2,
		STAT_FULL   = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		WR_NONE      = 3'd0,
		WR_INIT      = 3'd1,
		WR_CUR_USED  = 3'd2,
		WR_CUR_FREE  = 3'd3,
		WR_CUR_MERGE = 3'd4,
		WR_NEW_FREE  = 3'd5,
		WR_NXT_MERGE = 3'd6
	} wsel_t;

	typedef enum logic [1:0] {
		RD_SCAN  = 2'd0,
		RD_NEXT  = 2'd1,
		RD_SHIFT = 2'd2
	} rdsel_t;

	typedef struct packed {
		logic   req_load;
		logic   scan_start;
		logic   scan_en;
		logic   scan_alloc;
		logic   shup_start;
		logic   shdn_start;
		logic   shup_en;
		logic   shdn_en;
		rdsel_t rd_sel;
		wsel_t  wsel;
		logic   nxt_load;
		logic   count_init;
		logic   count_inc;
		logic   count_dec;
		logic   res_save;
		logic   out_load;
		stat_t  stat;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       len_zero;
		logic       scan_hit;
		logic       scan_miss;
		logic       cur_free;
		logic       fit_exact;
		logic       fit_ok;
		logic       nxt_exists;
		logic       nxt_free;
		logic       full;
		logic       shift_done;
		logic       out_free;
	} dp_stat_t;

endpackage

/* design/ffsa_ram.sv */
module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/ffsa_ctrl.sv */
module ffsa_ctrl import ffsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pool_bytes_we,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [15:0] {
		S_INIT   = 16'h0001,
		S_IDLE   = 16'h0002,
		S_DISP   = 16'h0004,
		S_ASCAN  = 16'h0008,
		S_AFIT   = 16'h0010,
		S_SHUP   = 16'h0020,
		S_WNEW   = 16'h0040,
		S_WCUR   = 16'h0080,
		S_FSCAN  = 16'h0100,
		S_FHIT   = 16'h0200,
		S_NRD    = 16'h0400,
		S_NCHK   = 16'h0800,
		S_MERGE  = 16'h1000,
		S_SHDN   = 16'h2000,
		S_SMERGE = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	state_t state_q, state_d;
	stat_t  stat_q, stat_d;
	logic   grow_q, grow_d;
	logic   init_pend_q;
	logic   free_path;

	assign in_ready  = (state_q == S_IDLE) && !init_pend_q;
	// grow reuses the free sequence on the old segment once the new one is placed
	assign free_path = (stat.req_type == RQ_FREE) || grow_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		stat_d  = stat_q;
		grow_d  = grow_q;
		unique case (state_q)
			S_INIT: begin
				cmd.wsel       = WR_INIT;
				cmd.count_init = 1'b1;
				state_d        = S_IDLE;
			end
			S_IDLE: begin
				if (init_pend_q) begin
					state_d = S_INIT;
				end else if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_DISP: begin
				grow_d = 1'b0;
				priority if (stat.req_type == RQ_ALLOC) begin
					if (stat.len_zero) begin
						stat_d  = STAT_NOFIT;
						state_d = S_DONE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_ASCAN;
					end
				end else if (stat.req_type == RQ_FREE || stat.req_type == RQ_RESIZE) begin
					cmd.scan_start = 1'b1;
					state_d        = S_FSCAN;
				end else begin
					stat_d  = STAT_NOFIT;
					state_d = S_DONE;
				end
			end
			S_ASCAN: begin
				cmd.scan_en    = 1'b1;
				cmd.scan_alloc = 1'b1;
				cmd.rd_sel     = RD_SCAN;
				if (stat.scan_hit) begin
					state_d = S_AFIT;
				end else if (stat.scan_miss) begin
					stat_d  = STAT_NOFIT;
					state_d = S_DONE;
				end
			end
			S_AFIT: begin
				priority if (stat.fit_exact) begin
					cmd.wsel     = WR_CUR_USED;
					cmd.res_save = 1'b1;
					if (grow_q) begin
						cmd.scan_start = 1'b1;
						state_d        = S_FSCAN;
					end else begin
						stat_d  = STAT_OK;
						state_d = S_DONE;
					end
				end else if (stat.full) begin
					stat_d  = STAT_FULL;
					state_d = S_DONE;
				end else begin
					cmd.shup_start = 1'b1;
					state_d        = S_SHUP;
				end
			end
			S_SHUP: begin
				cmd.shup_en = 1'b1;
				cmd.rd_sel  = RD_SHIFT;
				if (stat.shift_done) begin
					state_d = S_WNEW;
				end
			end
			S_WNEW: begin
				cmd.wsel      = WR_NEW_FREE;
				cmd.count_inc = 1'b1;
				state_d       = S_WCUR;
			end
			S_WCUR: begin
				cmd.wsel     = WR_CUR_USED;
				cmd.res_save = 1'b1;
				if (grow_q) begin
					cmd.scan_start = 1'b1;
					state_d        = S_FSCAN;
				end else begin
					stat_d  = STAT_OK;
					state_d = S_DONE;
				end
			end
			S_FSCAN: begin
				cmd.scan_en = 1'b1;
				cmd.rd_sel  = RD_SCAN;
				if (stat.scan_hit) begin
					state_d = S_FHIT;
				end else if (stat.scan_miss) begin
					stat_d  = STAT_NOADDR;
					state_d = S_DONE;
				end
			end
			S_FHIT: begin
				priority if (free_path) begin
					cmd.res_save = !grow_q;
					if (stat.nxt_exists) begin
						state_d = S_NRD;
					end else begin
						cmd.wsel = WR_CUR_FREE;
						stat_d   = STAT_OK;
						state_d  = S_DONE;
					end
				end else if (stat.cur_free) begin
					stat_d  = STAT_NOADDR;
					state_d = S_DONE;
				end else if (stat.len_zero) begin
					stat_d  = STAT_NOFIT;
					state_d = S_DONE;
				end else if (stat.fit_exact) begin
					cmd.res_save = 1'b1;
					stat_d       = STAT_OK;
					state_d      = S_DONE;
				end else if (stat.fit_ok) begin
					if (stat.nxt_exists) begin
						state_d = S_NRD;
					end else if (stat.full) begin
						stat_d  = STAT_FULL;
						state_d = S_DONE;
					end else begin
						cmd.shup_start = 1'b1;
						state_d        = S_SHUP;
					end
				end else begin
					grow_d         = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_ASCAN;
				end
			end
			S_NRD: begin
				cmd.rd_sel = RD_NEXT;
				state_d    = S_NCHK;
			end
			S_NCHK: begin
				cmd.nxt_load = 1'b1;
				priority if (free_path) begin
					if (stat.nxt_free) begin
						state_d = S_MERGE;
					end else begin
						cmd.wsel = WR_CUR_FREE;
						stat_d   = STAT_OK;
						state_d  = S_DONE;
					end
				end else if (stat.nxt_free) begin
					state_d = S_SMERGE;
				end else if (stat.full) begin
					stat_d  = STAT_FULL;
					state_d = S_DONE;
				end else begin
					cmd.shup_start = 1'b1;
					state_d        = S_SHUP;
				end
			end
			S_MERGE: begin
				cmd.wsel       = WR_CUR_MERGE;
				cmd.shdn_start = 1'b1;
				state_d        = S_SHDN;
			end
			S_SHDN: begin
				cmd.shdn_en = 1'b1;
				cmd.rd_sel  = RD_SHIFT;
				if (stat.shift_done) begin
					cmd.count_dec = 1'b1;
					stat_d        = STAT_OK;
					state_d       = S_DONE;
				end
			end
			S_SMERGE: begin
				cmd.wsel = WR_NXT_MERGE;
				state_d  = S_WCUR;
			end
			S_DONE: begin
				cmd.stat = stat_q;
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stat_q      <= STAT_OK;
			grow_q      <= 1'b0;
			init_pend_q <= 1'b1;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			grow_q  <= grow_d;
			if (pool_bytes_we) begin
				init_pend_q <= 1'b1;
			end else if (state_q == S_INIT) begin
				init_pend_q <= 1'b0;
			end
		end
	end

endmodule

/* design/ffsa_dp.sv */
module ffsa_dp import ffsa_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  logic                 pool_bytes_we,
	input  logic [ADDR_BITS:0]   pool_bytes,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] target_address,
	input  logic [ADDR_BITS:0]   request_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] result_address
);

	localparam int IW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int LW = ADDR_BITS + 1;
	localparam int EW = ADDR_BITS + LW + 1;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LW-1:0]        len;
		logic                 free;
	} entry_t;

	logic [LW-1:0]        pool_q, pool_clamp;
	logic [CW-1:0]        count_q;
	logic [1:0]           req_type_q;
	logic [ADDR_BITS-1:0] req_addr_q;
	logic [LW-1:0]        req_len_q;
	logic [CW-1:0]        ptr_q;
	logic                 chk_vld_s1;
	logic [IW-1:0]        chk_idx_s1;
	entry_t               cur_q;
	logic [IW-1:0]        cur_idx_q;
	logic [LW-1:0]        nxt_len_q;
	logic [CW-1:0]        sp_q;
	logic                 shv_s1;
	logic [IW-1:0]        shdst_s1;
	logic [ADDR_BITS-1:0] res_q;
	logic                 out_valid_q;
	stat_t                status_q;
	logic [ADDR_BITS-1:0] result_address_q;

	entry_t               rd_e, wdata;
	logic                 we;
	logic [IW-1:0]        waddr, raddr;
	logic                 scan_match, up_issue, dn_issue;
	logic [ADDR_BITS-1:0] split_start;

	ffsa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_SEGMENTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_e)
	);

	always_comb begin
		if (pool_bytes == '0) begin
			pool_clamp = LW'(1);
		end else if (pool_bytes[LW-1]) begin
			pool_clamp = {1'b1, {ADDR_BITS{1'b0}}};
		end else begin
			pool_clamp = pool_bytes;
		end
	end

	assign scan_match  = cmd.scan_alloc ? (rd_e.free && (rd_e.len >= req_len_q))
		: (rd_e.start == req_addr_q);
	assign up_issue    = cmd.shup_en && (sp_q > CW'(cur_idx_q));
	assign dn_issue    = cmd.shdn_en && (sp_q < count_q);
	assign split_start = cur_q.start + req_len_q[ADDR_BITS-1:0];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_SCAN:  raddr = ptr_q[IW-1:0];
			RD_NEXT:  raddr = cur_idx_q + IW'(1);
			RD_SHIFT: raddr = sp_q[IW-1:0];
			default:  raddr = ptr_q[IW-1:0];
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = cur_idx_q;
		wdata = cur_q;
		if (shv_s1) begin
			we    = 1'b1;
			waddr = shdst_s1;
			wdata = rd_e;
		end else begin
			unique case (cmd.wsel)
				WR_NONE: begin
				end
				WR_INIT: begin
					we    = 1'b1;
					waddr = '0;
					wdata = '{start: '0, len: pool_q, free: 1'b1};
				end
				WR_CUR_USED: begin
					we    = 1'b1;
					wdata = '{start: cur_q.start, len: req_len_q, free: 1'b0};
				end
				WR_CUR_FREE: begin
					we    = 1'b1;
					wdata = '{start: cur_q.start, len: cur_q.len, free: 1'b1};
				end
				WR_CUR_MERGE: begin
					we    = 1'b1;
					wdata = '{start: cur_q.start, len: cur_q.len + nxt_len_q, free: 1'b1};
				end
				WR_NEW_FREE: begin
					we    = 1'b1;
					waddr = cur_idx_q + IW'(1);
					wdata = '{start: split_start, len: cur_q.len - req_len_q, free: 1'b1};
				end
				WR_NXT_MERGE: begin
					we    = 1'b1;
					waddr = cur_idx_q + IW'(1);
					wdata = '{start: split_start, len: nxt_len_q + (cur_q.len - req_len_q),
						free: 1'b1};
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		stat            = '0;
		stat.req_type   = req_type_q;
		stat.len_zero   = (req_len_q == '0);
		stat.scan_hit   = cmd.scan_en && chk_vld_s1 && scan_match;
		stat.scan_miss  = cmd.scan_en && chk_vld_s1 && !scan_match
			&& ((CW'(chk_idx_s1) + CW'(1)) == count_q);
		stat.cur_free   = cur_q.free;
		stat.fit_exact  = (cur_q.len == req_len_q);
		stat.fit_ok     = (req_len_q <= cur_q.len);
		stat.nxt_exists = ((CW'(cur_idx_q) + CW'(1)) < count_q);
		stat.nxt_free   = rd_e.free;
		stat.full       = (count_q == CW'(MAX_SEGMENTS));
		stat.shift_done = !up_issue && !dn_issue && !shv_s1;
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q      <= {1'b1, {ADDR_BITS{1'b0}}};
			count_q     <= CW'(1);
			ptr_q       <= '0;
			chk_vld_s1  <= 1'b0;
			sp_q        <= '0;
			shv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pool_bytes_we) begin
				pool_q <= pool_clamp;
			end
			if (cmd.count_init) begin
				count_q <= CW'(1);
			end else if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_start) begin
				ptr_q <= '0;
			end else if (cmd.scan_en && (ptr_q < count_q)) begin
				ptr_q <= ptr_q + CW'(1);
			end
			chk_vld_s1 <= cmd.scan_en && (ptr_q < count_q);
			if (cmd.shup_start) begin
				sp_q <= count_q - CW'(1);
			end else if (cmd.shdn_start) begin
				sp_q <= CW'(cur_idx_q) + CW'(2);
			end else if (up_issue) begin
				sp_q <= sp_q - CW'(1);
			end else if (dn_issue) begin
				sp_q <= sp_q + CW'(1);
			end
			shv_s1 <= up_issue || dn_issue;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_type_q <= req_type;
			req_addr_q <= target_address;
			req_len_q  <= request_length;
		end
		chk_idx_s1 <= ptr_q[IW-1:0];
		if (stat.scan_hit) begin
			cur_q     <= rd_e;
			cur_idx_q <= chk_idx_s1;
		end
		if (cmd.nxt_load) begin
			nxt_len_q <= rd_e.len;
		end
		shdst_s1 <= up_issue ? IW'(sp_q + CW'(1)) : IW'(sp_q - CW'(1));
		if (cmd.res_save) begin
			res_q <= cur_q.start;
		end
		if (cmd.out_load) begin
			status_q         <= cmd.stat;
			result_address_q <= (cmd.stat == STAT_OK) ? res_q : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign result_address = result_address_q;

endmodule

/* design/first_fit_segment_allocator.sv */
// First-fit allocator over an address-ordered table of up to MAX_SEGMENTS segments
// kept in one RAM. Each request is processed alone: a scan reads one table entry per
// cycle, and an insert or removal moves one entry per cycle through the RAM's single
// read and write ports. Looking at the next entry passes through S_NRD and S_NCHK;
// a split or merge shifts the later entries as needed, and a grow pays two scans. The
// result sits in an output register, so the next request is taken while it waits.
// After reset and after each pool_bytes write the table is rebuilt as one free
// segment in S_INIT, and no request is taken before that is done.
module first_fit_segment_allocator import ffsa_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pool_bytes_we,
	input  logic [ADDR_BITS:0]   pool_bytes,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           req_type,
	input  logic [ADDR_BITS-1:0] target_address,
	input  logic [ADDR_BITS:0]   request_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [ADDR_BITS-1:0] result_address
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	ffsa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.pool_bytes_we (pool_bytes_we),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	ffsa_dp #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.ADDR_BITS    (ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.pool_bytes_we  (pool_bytes_we),
		.pool_bytes     (pool_bytes),
		.req_type       (req_type),
		.target_address (target_address),
		.request_length (request_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.result_address (result_address)
	);

endmodule

/* design/ffsa_chk.sv */
module ffsa_chk import ffsa_pkg::*; #(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [1:0]           status,
	input logic [ADDR_BITS-1:0] result_address
);

	// items taken but not yet delivered
	logic [2:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_address))
		else $error("result item changed while stalled");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> (result_address == '0))
		else $error("failed request returned a nonzero address");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pend_q != '0))
		else $error("result item without a request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more than two items in flight");

endmodule

bind first_fit_segment_allocator ffsa_chk #(
	.ADDR_BITS (ADDR_BITS)
) u_ffsa_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.result_address (result_address)
);

/* tb/first_fit_segment_allocator_test.sv */
module first_fit_segment_allocator_test import ffsa_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEGS = MAX_SEGMENTS_DEF;
	localparam int AW = ADDR_BITS_DEF;
	localparam int POOL_LIMIT = 1 << AW;
	localparam logic [1:0] RQ_UNKNOWN = 2'd3;
	localparam int SETTLE_CYCLES = 3 * SEGS + 20;

	typedef struct {
		logic [1:0]    kind;
		logic [AW-1:0] addr;
		logic [AW:0]   len;
	} request_t;

	typedef struct {
		stat_t         st;
		logic [AW-1:0] addr;
	} answer_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          pool_bytes_we = 1'b0;
	logic [AW:0]   pool_bytes = 17'h10000;
	logic          in_valid = 1'b0;
	logic          in_ready;
	logic [1:0]    req_type = RQ_ALLOC;
	logic [AW-1:0] target_address = '0;
	logic [AW:0]   request_length = '0;
	logic          out_valid;
	logic          out_ready = 1'b0;
	logic [1:0]    status;
	logic [AW-1:0] result_address;

	first_fit_segment_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.pool_bytes_we(pool_bytes_we),
		.pool_bytes(pool_bytes),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.target_address(target_address),
		.request_length(request_length),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.result_address(result_address)
	);

	// segment table as the allocator should hold it
	int unsigned   pool_sz;
	logic [AW-1:0] seg_base [SEGS];
	logic [AW:0]   seg_size [SEGS];
	bit            seg_avail [SEGS];
	int            seg_n;

	request_t request_backlog[$];
	answer_t  answers_due[$];
	request_t cur;
	bit       holding = 1'b0;
	bit       sent_flag = 1'b0;
	int       send_gap = 0;
	bit       eager = 1'b0;
	bit       long_hold_req = 1'b0;
	int       hold_left = 0;
	int       stall_left = 0;
	int       pushed_cnt = 0;
	int       answered_cnt = 0;
	int       errors = 0;
	int       settings_used = 0;
	int       stat_seen [4];

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("first_fit_segment_allocator_test failed");
		$finish;
	end

	function automatic void rebuild_table();
		for (int i = 0; i < SEGS; i++) begin
			seg_base[i] = '0;
			seg_size[i] = '0;
			seg_avail[i] = 1'b0;
		end
		seg_size[0] = (AW+1)'(pool_sz);
		seg_avail[0] = 1'b1;
		seg_n = 1;
	endfunction

	function automatic int find_start(logic [AW-1:0] a);
		for (int i = 0; i < seg_n; i++)
			if (seg_base[i] == a)
				return i;
		return -1;
	endfunction

	function automatic void open_slot(int i, logic [AW-1:0] s, logic [AW:0] l, bit fr);
		for (int k = seg_n; k > i + 1; k--) begin
			seg_base[k] = seg_base[k-1];
			seg_size[k] = seg_size[k-1];
			seg_avail[k] = seg_avail[k-1];
		end
		seg_base[i+1] = s;
		seg_size[i+1] = l;
		seg_avail[i+1] = fr;
		seg_n++;
	endfunction

	function automatic void close_slot(int i);
		for (int k = i; k + 1 < seg_n; k++) begin
			seg_base[k] = seg_base[k+1];
			seg_size[k] = seg_size[k+1];
			seg_avail[k] = seg_avail[k+1];
		end
		seg_n--;
		seg_base[seg_n] = '0;
		seg_size[seg_n] = '0;
		seg_avail[seg_n] = 1'b0;
	endfunction

	function automatic void release_at(int i);
		seg_avail[i] = 1'b1;
		if (i + 1 < seg_n && seg_avail[i+1]) begin
			seg_size[i] = seg_size[i] + seg_size[i+1];
			close_slot(i + 1);
		end
	endfunction

	function automatic stat_t grant(logic [AW:0] len, output logic [AW-1:0] a);
		a = '0;
		if (len == '0)
			return STAT_NOFIT;
		for (int i = 0; i < seg_n; i++) begin
			if (seg_avail[i] && seg_size[i] >= len) begin
				if (seg_size[i] > len) begin
					if (seg_n >= SEGS)
						return STAT_FULL;
					open_slot(i, AW'(seg_base[i] + len), seg_size[i] - len, 1'b1);
					seg_size[i] = len;
				end
				seg_avail[i] = 1'b0;
				a = seg_base[i];
				return STAT_OK;
			end
		end
		return STAT_NOFIT;
	endfunction

	function automatic stat_t reshape(logic [AW-1:0] addr, logic [AW:0] len,
			output logic [AW-1:0] a);
		int f;
		logic [AW:0] rem;
		logic [AW-1:0] na;
		stat_t st;
		a = '0;
		f = find_start(addr);
		if (f < 0 || seg_avail[f])
			return STAT_NOADDR;
		if (len == '0)
			return STAT_NOFIT;
		if (len <= seg_size[f]) begin
			rem = seg_size[f] - len;
			if (rem != '0) begin
				if (f + 1 < seg_n && seg_avail[f+1]) begin
					seg_base[f+1] = AW'(seg_base[f+1] - rem);
					seg_size[f+1] = seg_size[f+1] + rem;
				end else begin
					if (seg_n >= SEGS)
						return STAT_FULL;
					open_slot(f, AW'(seg_base[f] + len), rem, 1'b1);
				end
				seg_size[f] = len;
			end
			a = addr;
			return STAT_OK;
		end
		st = grant(len, na);
		if (st != STAT_OK)
			return st;
		f = find_start(addr);
		if (f >= 0)
			release_at(f);
		a = na;
		return STAT_OK;
	endfunction

	function automatic answer_t serve_request(logic [1:0] kind, logic [AW-1:0] addr,
			logic [AW:0] len);
		answer_t r;
		int f;
		r.addr = '0;
		case (kind)
			RQ_ALLOC: r.st = grant(len, r.addr);
			RQ_FREE: begin
				f = find_start(addr);
				if (f < 0) begin
					r.st = STAT_NOADDR;
				end else begin
					release_at(f);
					r.addr = addr;
					r.st = STAT_OK;
				end
			end
			RQ_RESIZE: r.st = reshape(addr, len, r.addr);
			default: r.st = STAT_NOFIT;
		endcase
		if (r.st != STAT_OK)
			r.addr = '0;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = int'($urandom_range(0, 99));
		if (eager || r < 50)
			return 0;
		if (r < 85)
			return int'($urandom_range(1, 3));
		if (r < 97)
			return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	task automatic flag_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// sender
	always @(negedge clk) begin : sender
		if (arst_n) begin
			if (sent_flag) begin
				sent_flag = 1'b0;
				holding = 1'b0;
			end
			if (!holding) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (request_backlog.size() > 0) begin
					cur = request_backlog.pop_front();
					holding = 1'b1;
					send_gap = pick_gap();
				end
			end
			in_valid <= holding;
			req_type <= cur.kind;
			target_address <= cur.addr;
			request_length <= cur.len;
		end
	end

	// receiver; a long hold is counted here
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = 400;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!eager && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// result check first, then prediction of the item taken at this edge
	always @(posedge clk) begin : result_check
		answer_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				answered_cnt++;
				if (answers_due.size() == 0) begin
					flag_mismatch($sformatf("result st=%0d addr=%0h with nothing pending",
						status, result_address));
				end else begin
					want = answers_due.pop_front();
					if (status !== want.st)
						flag_mismatch($sformatf("status %0d, expected %0d", status, want.st));
					if (result_address !== want.addr)
						flag_mismatch($sformatf("address %0h, expected %0h",
							result_address, want.addr));
				end
			end
			if (in_valid && in_ready) begin
				want = serve_request(req_type, target_address, request_length);
				stat_seen[want.st]++;
				answers_due.push_back(want);
				sent_flag = 1'b1;
			end
		end
	end

	task automatic push_item(logic [1:0] kind, logic [AW-1:0] addr, logic [AW:0] len);
		request_t it;
		it.kind = kind;
		it.addr = addr;
		it.len = len;
		request_backlog.push_back(it);
		pushed_cnt++;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pushed_cnt != answered_cnt);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_pool(logic [AW:0] v);
		int unsigned p;
		wait_idle();
		pool_bytes_we <= 1'b1;
		pool_bytes <= v;
		p = 32'(v);
		if (p == 0)
			p = 1;
		if (p > POOL_LIMIT)
			p = POOL_LIMIT;
		pool_sz = p;
		rebuild_table();
		settings_used++;
		@(negedge clk);
		pool_bytes_we <= 1'b0;
	endtask

	// mostly requests aimed at live segments, with some noise
	task automatic queue_random(int n);
		int r;
		int idx;
		int unsigned small_max;
		logic [1:0] kind;
		logic [AW-1:0] addr;
		logic [AW:0] len;
		for (int j = 0; j < n; j++) begin
			while (request_backlog.size() >= 2)
				@(negedge clk);
			r = int'($urandom_range(0, 99));
			kind = (r < 45) ? RQ_ALLOC : (r < 73) ? RQ_FREE : (r < 98) ? RQ_RESIZE : RQ_UNKNOWN;
			idx = int'($urandom_range(0, seg_n - 1));
			r = int'($urandom_range(0, 19));
			if (r == 0)
				addr = AW'($urandom);
			else if (r == 1)
				addr = AW'(seg_base[idx] + 1);
			else
				addr = seg_base[idx];
			small_max = (pool_sz / 12 > 1) ? pool_sz / 12 : 1;
			r = int'($urandom_range(0, 99));
			if (r < 3)
				len = '0;
			else if (r < 6)
				len = (AW+1)'(POOL_LIMIT);
			else if (r < 10)
				len = (AW+1)'($urandom_range(1, POOL_LIMIT));
			else if (r < 20)
				len = (AW+1)'($urandom_range(1, pool_sz));
			else
				len = (AW+1)'($urandom_range(1, small_max));
			if (kind == RQ_RESIZE && $urandom_range(0, 1) == 1 && seg_size[idx] != '0) begin
				if ($urandom_range(0, 1) == 1)
					len = (AW+1)'($urandom_range(1, seg_size[idx]));
				else
					len = (AW+1)'(seg_size[idx] + $urandom_range(1, small_max));
			end
			push_item(kind, addr, len);
		end
	endtask

	initial begin : stimulus
		logic [AW:0] pools [10];
		pool_sz = POOL_LIMIT;
		rebuild_table();
		settings_used = 1;
		foreach (stat_seen[i])
			stat_seen[i] = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(RQ_ALLOC, 16'd0, 17'd0);
		push_item(RQ_ALLOC, 16'd0, 17'h10000);
		push_item(RQ_ALLOC, 16'd0, 17'd1);
		push_item(RQ_FREE, 16'd0, 17'd0);
		push_item(RQ_ALLOC, 16'd0, 17'd100);
		push_item(RQ_ALLOC, 16'd0, 17'd200);
		push_item(RQ_FREE, 16'd12345, 17'd0);
		push_item(RQ_RESIZE, 16'd300, 17'd10);
		push_item(RQ_RESIZE, 16'd100, 17'd0);
		push_item(RQ_RESIZE, 16'd100, 17'd150);
		push_item(RQ_RESIZE, 16'd0, 17'd60);
		push_item(RQ_RESIZE, 16'd0, 17'd5000);
		push_item(RQ_FREE, 16'd100, 17'd0);
		push_item(RQ_FREE, 16'd100, 17'd0);
		push_item(RQ_UNKNOWN, 16'hFFFF, 17'h1FFFF);
		push_item(RQ_FREE, 16'hFFFF, 17'd0);
		push_item(RQ_RESIZE, 16'hFFFF, 17'h10000);
		push_item(RQ_ALLOC, 16'd0, 17'h10000);

		// zero pool size is taken as one byte
		write_pool(17'd0);
		push_item(RQ_ALLOC, 16'd0, 17'd1);
		push_item(RQ_ALLOC, 16'd0, 17'd1);
		push_item(RQ_RESIZE, 16'd0, 17'd2);
		push_item(RQ_FREE, 16'd0, 17'd0);

		// oversize pool write clamps to the full address space
		write_pool(17'h1FFFF);
		push_item(RQ_ALLOC, 16'd0, 17'h10000);
		push_item(RQ_FREE, 16'd0, 17'd0);

		pools = '{17'd1, 17'd0, 17'd37, 17'd300, 17'h10000, 17'd0,
			17'h1FFFF, 17'd4096, 17'd0, 17'd64};
		pools[5] = (AW+1)'($urandom_range(2, POOL_LIMIT));
		pools[8] = (AW+1)'($urandom_range(2, 1000));
		for (int ph = 0; ph < 10; ph++) begin
			write_pool(pools[ph]);
			eager = (ph == 4 || ph == 7);
			if (ph == 3 || ph == 8)
				long_hold_req = 1'b1;
			queue_random(103);
		end

		do
			@(negedge clk);
		while (pushed_cnt != answered_cnt);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("%0d requests over %0d pool sizes, with long output stalls and idle drains",
			pushed_cnt, settings_used);
		$display("outcomes: ok %0d, no fit %0d, bad address %0d, full %0d",
			stat_seen[STAT_OK], stat_seen[STAT_NOFIT],
			stat_seen[STAT_NOADDR], stat_seen[STAT_FULL]);
		if (errors == 0 && answers_due.size() == 0)
			$display("first_fit_segment_allocator_test passed");
		else
			$display("first_fit_segment_allocator_test failed");
		$finish;
	end

endmodule
